// ----- rtl/hrhp_pkg.sv -----
`default_nettype none
package hrhp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_connection;
    } t_in_item;

    typedef struct packed {
        logic              status;
        logic [7:0]        path_byte;
        logic signed [31:0] body_len;
        logic              last;
    } t_out_item;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [31:0] LEN_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] LEN_MAG_MAX = 32'h8000_0000;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b inside {[8'h41:8'h5A]}) ? b + 8'd32 : b;
    endfunction

    function automatic logic [7:0] get_chr(input logic [1:0] i);
        case (i)
            2'd0:    return 8'h47;
            2'd1:    return 8'h45;
            2'd2:    return 8'h54;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] proto_chr(input logic [2:0] i);
        case (i)
            3'd0:    return 8'h48;
            3'd1:    return 8'h54;
            3'd2:    return 8'h54;
            3'd3:    return 8'h50;
            3'd4:    return 8'h2F;
            3'd5:    return 8'h31;
            3'd6:    return 8'h2E;
            3'd7:    return 8'h30;
            default: return 8'h00;
        endcase
    endfunction

    // content-length
    function automatic logic [7:0] key_chr(input logic [3:0] i);
        case (i)
            4'd0:    return 8'h63;
            4'd1:    return 8'h6F;
            4'd2:    return 8'h6E;
            4'd3:    return 8'h74;
            4'd4:    return 8'h65;
            4'd5:    return 8'h6E;
            4'd6:    return 8'h74;
            4'd7:    return 8'h2D;
            4'd8:    return 8'h6C;
            4'd9:    return 8'h65;
            4'd10:   return 8'h6E;
            4'd11:   return 8'h67;
            4'd12:   return 8'h74;
            4'd13:   return 8'h68;
            default: return 8'h00;
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- rtl/http_request_header_parser.sv -----
// A bad-request item appears in the output register in the cycle after its byte is accepted.
// One byte per cycle while parsing, unless a stalled output item holds the input off;
// the path run reads the path memory (synchronous read, S_READ then S_SEND), input held off.
// Reset (synchronous, active low) clears the parse state and the output valid flag;
// the path memory is not cleared, only entries written for the current request are read.
`default_nettype none
module http_request_header_parser
    import hrhp_pkg::*;
#(
    parameter int WORD_MAX = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_data
);

    localparam int AW = $clog2(WORD_MAX);
    localparam logic [AW-1:0] WLEN_LIM = AW'(WORD_MAX - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SEND = 3'b100
    } t_state;

    typedef struct packed {
        logic [AW-1:0] wlen;
        logic [AW-1:0] plen;
        logic          past;
        logic [1:0]    wpos;
        logic          lempty;
        logic          lunf;
        logic          meth;
        logic          lhdr;
        logic [31:0]   lval;
        logic          pcr;
        logic          fin;
        logic          m_get;
        logic          m_proto;
        logic          m_key;
        logic          col_seen;
        logic          col14;
        logic          lead_col;
        logic          first_slash;
        logic          dotbad;
        logic          prev_s;
        logic          prev_sd;
        logic          q_seen;
        logic          cv_on;
        logic          cv_neg;
        logic [31:0]   cv_mag;
    } t_ctx;

    localparam t_ctx CTX_RST = '{
        wlen: '0, plen: '0, past: 1'b0, wpos: 2'd0, lempty: 1'b1, lunf: 1'b1,
        meth: 1'b0, lhdr: 1'b0, lval: 32'hFFFF_FFFF, pcr: 1'b0, fin: 1'b0,
        m_get: 1'b0, m_proto: 1'b0, m_key: 1'b0, col_seen: 1'b0, col14: 1'b0,
        lead_col: 1'b0, first_slash: 1'b0, dotbad: 1'b0, prev_s: 1'b0, prev_sd: 1'b0,
        q_seen: 1'b0, cv_on: 1'b0, cv_neg: 1'b0, cv_mag: '0
    };

    t_state        r_state, n_state;
    t_ctx          r_ctx, n_ctx;
    logic [AW-1:0] r_addr, n_addr;
    logic [7:0]    r_rd_data;
    logic          r_out_vld, n_out_vld;
    t_out_item     r_out, n_out;
    logic [7:0]    path_mem [WORD_MAX];

    logic          acc;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    assign o_stall = (r_state != S_IDLE) || (r_out_vld && i_stall);
    assign acc     = i_valid && !o_stall;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            path_mem[wr_addr] <= i_data.data_byte;
        end
        r_rd_data <= path_mem[r_addr];
    end

    always_comb begin
        t_ctx        c;
        logic [7:0]  b;
        logic [AW-1:0] i;
        logic        first;
        logic        from1;
        logic        at_from;
        logic        digit;
        logic [3:0]  d;
        logic [35:0] t;
        logic [31:0] cv;
        logic        bad;
        logic        run;
        logic        take;
        logic        is_eol;

        c       = i_data.new_connection ? CTX_RST : r_ctx;
        b       = i_data.data_byte;
        i       = c.wlen;
        first   = (i == '0);
        n_ctx   = r_ctx;
        n_state = r_state;
        n_addr  = r_addr;
        n_out   = r_out;
        n_out_vld = r_out_vld && i_stall;
        wr_en   = 1'b0;
        wr_addr = c.plen;
        bad     = 1'b0;
        run     = 1'b0;
        take    = 1'b0;
        digit   = b inside {[8'h30:8'h39]};
        d       = b[3:0];
        from1   = c.past && (c.wpos == 2'd1);
        at_from = from1 ? (i == AW'(1)) : first;
        t       = ({4'd0, c.cv_mag} << 3) + ({4'd0, c.cv_mag} << 1) + {32'd0, d};
        cv      = c.cv_neg ? (32'd0 - c.cv_mag)
                           : ((c.cv_mag > LEN_POS_MAX) ? LEN_POS_MAX : c.cv_mag);
        is_eol  = (b == CH_LF) || (b == CH_CR);

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_ctx = c;
                    if (!c.fin) begin
                        n_ctx.pcr = 1'b0;
                        if (!is_space(b)) begin
                            if (c.wlen >= WLEN_LIM) begin
                                bad = 1'b1;
                            end else begin
                                n_ctx.m_get = (first || c.m_get) && (i < AW'(3))
                                              && (b == get_chr(i[1:0]));
                                n_ctx.m_proto = (first || c.m_proto) && (i < AW'(8))
                                                && (b == proto_chr(i[2:0]));
                                // hold the key match past its last letter
                                n_ctx.m_key = (first || c.m_key) && ((i >= AW'(14)) ||
                                              (to_lower(b) == key_chr(i[3:0])));
                                if (b == CH_COLON && (first || !c.col_seen)) begin
                                    n_ctx.col_seen = 1'b1;
                                    n_ctx.col14    = (i == AW'(14));
                                end else if (first) begin
                                    n_ctx.col_seen = 1'b0;
                                    n_ctx.col14    = 1'b0;
                                end
                                if (first) begin
                                    n_ctx.first_slash = (b == CH_SLASH);
                                    n_ctx.lead_col    = (b == CH_COLON);
                                end
                                n_ctx.dotbad  = (!first && c.dotbad) ||
                                                (!first && c.prev_sd && b == CH_DOT);
                                n_ctx.prev_s  = (b == CH_SLASH);
                                n_ctx.prev_sd = !first && c.prev_s && (b == CH_DOT);
                                n_ctx.q_seen  = (!first && c.q_seen) || (b == CH_QUEST);
                                // keep the path up to its first '?'
                                if (!c.past && c.wpos == 2'd1) begin
                                    if (first) begin
                                        n_ctx.plen = '0;
                                    end
                                    if (!(b == CH_QUEST) && (first || !c.q_seen)) begin
                                        wr_en   = 1'b1;
                                        wr_addr = first ? '0 : c.plen;
                                        n_ctx.plen = wr_addr + AW'(1);
                                    end
                                end
                                if (at_from) begin
                                    n_ctx.cv_neg = (b == CH_MINUS);
                                    if (b == CH_PLUS || b == CH_MINUS) begin
                                        n_ctx.cv_on  = 1'b1;
                                        n_ctx.cv_mag = '0;
                                    end else if (digit) begin
                                        n_ctx.cv_on  = 1'b1;
                                        n_ctx.cv_mag = {28'd0, d};
                                    end else begin
                                        n_ctx.cv_on  = 1'b0;
                                        n_ctx.cv_mag = '0;
                                    end
                                end else if (!(from1 && first)) begin
                                    if (c.cv_on && digit) begin
                                        n_ctx.cv_mag = (t > {4'd0, LEN_MAG_MAX}) ?
                                                       LEN_MAG_MAX : t[31:0];
                                    end else begin
                                        n_ctx.cv_on = 1'b0;
                                    end
                                end
                                n_ctx.wlen = c.wlen + AW'(1);
                            end
                        end else if (!(c.pcr && b == CH_LF)) begin
                            if (c.wlen != '0) begin
                                n_ctx.wlen   = '0;
                                n_ctx.lempty = 1'b0;
                                if (!c.past) begin
                                    case (c.wpos)
                                        2'd0: begin
                                            n_ctx.wpos = 2'd1;
                                            n_ctx.lunf = 1'b1;
                                            n_ctx.meth = c.m_get && (c.wlen == AW'(3));
                                            bad = !(c.m_get && (c.wlen == AW'(3)));
                                        end
                                        2'd1: begin
                                            n_ctx.wpos = 2'd2;
                                            bad = !c.first_slash || c.dotbad;
                                        end
                                        2'd2: begin
                                            n_ctx.wpos = 2'd3;
                                            n_ctx.lunf = 1'b0;
                                            bad = !(c.m_proto && (c.wlen == AW'(8)));
                                        end
                                        default: bad = 1'b1;
                                    endcase
                                end else begin
                                    case (c.wpos)
                                        2'd0: begin
                                            n_ctx.lunf = 1'b1;
                                            n_ctx.lhdr = c.m_key &&
                                                (c.col_seen ? c.col14
                                                            : (c.wlen == AW'(14)));
                                            n_ctx.wpos = c.col_seen ? 2'd2 : 2'd1;
                                        end
                                        2'd1: begin
                                            n_ctx.wpos = 2'd2;
                                            // value word must open with a colon
                                            bad  = !c.lead_col;
                                            take = !bad && (c.wlen > AW'(1));
                                        end
                                        2'd2: take = 1'b1;
                                        default: bad = 1'b1;
                                    endcase
                                    if (take) begin
                                        n_ctx.wpos = 2'd3;
                                        n_ctx.lunf = 1'b0;
                                        if (c.lhdr) begin
                                            n_ctx.lval = cv;
                                        end
                                    end
                                end
                            end
                            if (!bad && is_eol) begin
                                if (n_ctx.lempty) begin
                                    if (!n_ctx.meth || n_ctx.plen == '0) begin
                                        bad = 1'b1;
                                    end else begin
                                        run = 1'b1;
                                    end
                                end else if (n_ctx.lunf) begin
                                    bad = 1'b1;
                                end else begin
                                    n_ctx.lempty = 1'b1;
                                    n_ctx.past   = 1'b1;
                                    n_ctx.wpos   = 2'd0;
                                end
                                n_ctx.pcr = (b == CH_CR);
                            end
                        end
                        if (bad) begin
                            n_ctx.fin = 1'b1;
                            n_out_vld = 1'b1;
                            n_out.status    = 1'b1;
                            n_out.path_byte = 8'd0;
                            n_out.body_len  = n_ctx.lval;
                            n_out.last      = 1'b1;
                        end
                        if (run) begin
                            n_ctx.fin = 1'b1;
                            n_addr    = '0;
                            n_state   = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld = 1'b1;
                    n_out.status    = 1'b0;
                    n_out.path_byte = r_rd_data;
                    n_out.body_len  = r_ctx.lval;
                    n_out.last      = (r_addr + AW'(1) == r_ctx.plen);
                    if (r_addr + AW'(1) == r_ctx.plen) begin
                        n_state = S_IDLE;
                    end else begin
                        n_addr  = r_addr + AW'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ctx     <= CTX_RST;
            r_addr    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ctx     <= n_ctx;
            r_addr    <= n_addr;
            r_out_vld <= n_out_vld;
        end
        r_out <= n_out;
    end

endmodule
`default_nettype wire

// ----- tb/tb_http_request_header_parser.sv -----
`default_nettype none
module tb_http_request_header_parser;
    import hrhp_pkg::*;

    localparam int WORD_MAX   = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_ITEMS    = 270;

    typedef struct {
        logic [7:0]  data;
        logic        newconn;
        logic        has_result;
        t_out_item   result;
    } t_row;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    http_request_header_parser #(.WORD_MAX(WORD_MAX)) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_item),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_item)
    );

    // parser state kept by the predictor
    logic [7:0]  p_word [WORD_MAX];
    int          p_wlen;
    logic [7:0]  p_path [WORD_MAX];
    int          p_plen;
    logic        p_past_first;
    int          p_wpos;
    logic        p_line_empty;
    logic        p_line_open;
    logic        p_get_seen;
    logic        p_len_hdr;
    logic [31:0] p_len;
    logic        p_cr;
    logic        p_done;

    t_out_item expected_items[$];
    int        errors;
    int        idle_cycles;
    int        n_items_in;
    int        n_items_out;
    int        n_bad;
    int        n_runs;

    t_row      rows[$];
    logic      stall_pattern [16];
    byte       stream[$];
    logic      newconn_q[$];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    task automatic clear_parser();
        p_wlen = 0;
        p_plen = 0;
        p_past_first = 1'b0;
        p_wpos = 0;
        p_line_empty = 1'b1;
        p_line_open = 1'b1;
        p_get_seen = 1'b0;
        p_len_hdr = 1'b0;
        p_len = 32'hFFFF_FFFF;
        p_cr = 1'b0;
        p_done = 1'b0;
    endtask

    task automatic push_bad();
        t_out_item r;
        r.status = 1'b1;
        r.path_byte = 8'h00;
        r.body_len = p_len;
        r.last = 1'b1;
        expected_items.push_back(r);
        p_done = 1'b1;
        n_bad++;
    endtask

    function automatic logic word_matches(input string s);
        if (p_wlen != s.len()) return 1'b0;
        for (int i = 0; i < s.len(); i++)
            if (p_word[i] != s[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] atoi_sat(input int from);
        logic [63:0] mag;
        logic        neg;
        int          i;
        mag = 0;
        neg = 1'b0;
        i = from;
        if (i < p_wlen && (p_word[i] == CH_PLUS || p_word[i] == CH_MINUS)) begin
            neg = p_word[i] == CH_MINUS;
            i++;
        end
        while (i < p_wlen && p_word[i] >= "0" && p_word[i] <= "9") begin
            mag = mag * 10 + (p_word[i] - "0");
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            i++;
        end
        if (neg) return 32'd0 - mag[31:0];
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    // returns 1 on a fault
    function automatic logic finish_word();
        int  cut;
        int  colon_at;
        logic same;
        logic [7:0] c;
        string key;
        key = "content-length";
        p_line_empty = 1'b0;
        if (!p_past_first) begin
            case (p_wpos)
                0: begin
                    p_wpos = 1;
                    p_line_open = 1'b1;
                    p_get_seen = word_matches("GET");
                    return !p_get_seen;
                end
                1: begin
                    p_wpos = 2;
                    if (p_word[0] != CH_SLASH) return 1'b1;
                    for (int i = 0; i + 2 < p_wlen; i++)
                        if (p_word[i] == CH_SLASH && p_word[i+1] == CH_DOT &&
                            p_word[i+2] == CH_DOT) return 1'b1;
                    p_plen = 0;
                    for (int i = 0; i < p_wlen && p_word[i] != CH_QUEST; i++) begin
                        p_path[p_plen] = p_word[i];
                        p_plen++;
                    end
                    return 1'b0;
                end
                2: begin
                    p_wpos = 3;
                    p_line_open = 1'b0;
                    return !word_matches("HTTP/1.0");
                end
                default: return 1'b1;
            endcase
        end
        if (p_wpos == 0) begin
            p_wpos = 1;
            p_line_open = 1'b1;
            p_len_hdr = 1'b0;
            cut = p_wlen;
            for (int i = 0; i < p_wlen; i++)
                if (p_word[i] == CH_COLON) begin
                    cut = i;
                    break;
                end
            if (cut == 14) begin
                same = 1'b1;
                for (int i = 0; i < 14; i++) begin
                    c = p_word[i];
                    if (c >= "A" && c <= "Z") c = c + 8'd32;
                    if (c != key[i])
                        same = 1'b0;
                end
                p_len_hdr = same;
            end
            if (cut < p_wlen) p_wpos = 2;
            return 1'b0;
        end
        if (p_wpos == 1) begin
            p_wpos = 2;
            if (p_word[0] != CH_COLON) return 1'b1;
            if (p_wlen <= 1) return 1'b0;
            colon_at = 1;
        end else if (p_wpos == 2) begin
            colon_at = 0;
        end else begin
            return 1'b1;
        end
        p_wpos = 3;
        p_line_open = 1'b0;
        if (p_len_hdr) p_len = atoi_sat(colon_at);
        return 1'b0;
    endfunction

    task automatic close_line();
        t_out_item r;
        if (p_line_empty) begin
            if (!p_get_seen || p_plen == 0) begin
                push_bad();
                return;
            end
            for (int i = 0; i < p_plen; i++) begin
                r.status = 1'b0;
                r.path_byte = p_path[i];
                r.body_len = p_len;
                r.last = (i + 1 == p_plen);
                expected_items.push_back(r);
            end
            p_done = 1'b1;
            n_runs++;
            return;
        end
        if (p_line_open) begin
            push_bad();
            return;
        end
        p_line_empty = 1'b1;
        p_past_first = 1'b1;
        p_wpos = 0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic nc);
        logic was_cr;
        if (nc) clear_parser();
        if (p_done) return;
        was_cr = p_cr;
        p_cr = 1'b0;
        if (!is_ws(b)) begin
            if (p_wlen >= WORD_MAX - 1) begin
                push_bad();
                return;
            end
            p_word[p_wlen] = b;
            p_wlen++;
            return;
        end
        if (was_cr && b == CH_LF) return;
        if (p_wlen > 0) begin
            if (finish_word()) begin
                p_wlen = 0;
                push_bad();
                return;
            end
            p_wlen = 0;
        end
        if (b == CH_LF) close_line();
        else if (b == CH_CR) begin
            p_cr = 1'b1;
            close_line();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at item %0d: %s got %h expected %h", n_items_out, what, got, want);
        errors++;
    endtask

    // output side: stall pattern and checking
    always @(negedge clk) begin
        if (!rst_n) out_stall <= 1'b0;
        else out_stall <= stall_pattern[$urandom_range(0, 15)];
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_items.size() == 0) begin
                report_mismatch("unexpected item", 32'(out_item.path_byte), 32'd0);
            end else begin
                want = expected_items.pop_front();
                if (out_item.status !== want.status)
                    report_mismatch("status", 32'(out_item.status), 32'(want.status));
                if (out_item.path_byte !== want.path_byte)
                    report_mismatch("path_byte", 32'(out_item.path_byte),
                                    32'(want.path_byte));
                if (out_item.body_len !== want.body_len)
                    report_mismatch("body_len", out_item.body_len, want.body_len);
                if (out_item.last !== want.last)
                    report_mismatch("last", 32'(out_item.last), 32'(want.last));
            end
            n_items_out++;
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic nc);
        in_item.data_byte <= b;
        in_item.new_connection <= nc;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_byte(b, nc);
        n_items_in++;
        @(negedge clk);
    endtask

    task automatic gap(input int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            stream.push_back(s[i]);
            newconn_q.push_back(1'b0);
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic nc, input logic chk,
                           input logic st, input logic [31:0] len);
        t_row r;
        r.data = b;
        r.newconn = nc;
        r.has_result = chk;
        r.result.status = st;
        r.result.path_byte = 8'h00;
        r.result.body_len = len;
        r.result.last = 1'b1;
        rows.push_back(r);
    endtask

    function automatic string rand_word(input int n, input int kind);
        string s;
        byte   c;
        s = "";
        for (int i = 0; i < n; i++) begin
            case (kind)
                0: c = byte'($urandom_range(8'h21, 8'h7E));
                1: c = byte'($urandom_range("0", "9"));
                default: begin
                    c = byte'($urandom_range(0, 255));
                    if (is_ws(c) || c == 0) c = "x";
                end
            endcase
            s = {s, string'(c)};
        end
        return s;
    endfunction

    function automatic string line_end();
        case ($urandom_range(0, 2))
            0: return "\r\n";
            1: return "\n";
            default: return "\r";
        endcase
    endfunction

    // builds one request, mostly well-formed
    task automatic build_request();
        string s;
        string path;
        string sep;
        string sign;
        int    faults;
        faults = $urandom_range(0, 9) < 3;
        path = {"/", rand_word($urandom_range(0, 10), 0)};
        if ($urandom_range(0, 3) == 0) path = {path, "?", rand_word(3, 0)};
        if (faults && $urandom_range(0, 2) == 0) path = {path, "/..", "a"};
        s = faults && $urandom_range(0, 3) == 0 ? "get" : "GET";
        sep = " ";
        if ($urandom_range(0, 1)) sep = "\t ";
        s = {s, sep, path, " "};
        s = {s, faults && $urandom_range(0, 3) == 0 ? "HTTP/1.1" : "HTTP/1.0", line_end()};
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 4))
                0: begin
                    sign = "";
                    if ($urandom_range(0, 1)) sign = "-";
                    s = {s, "Content-Length: ", sign,
                         rand_word($urandom_range(1, 12), 1), line_end()};
                end
                1: s = {s, "content-LENGTH :", rand_word($urandom_range(1, 4), 1),
                        line_end()};
                2: s = {s, "X-", rand_word(4, 0), " : ", rand_word(5, 0), line_end()};
                3: s = {s, rand_word(6, 2), ": ", rand_word(6, 2), line_end()};
                default: s = {s, "Host:", rand_word(7, 0), line_end()};
            endcase
        end
        if (faults && $urandom_range(0, 1)) s = {s, "Bad:glued", line_end()};
        s = {s, line_end()};
        add_text(s);
        newconn_q[newconn_q.size() - s.len()] = 1'b1;
        // a few trailing bytes after the outcome are ignored
        repeat ($urandom_range(0, 2)) begin
            stream.push_back(byte'($urandom_range(0, 255)));
            newconn_q.push_back(1'b0);
        end
    endtask

    initial begin
        int    k;
        errors = 0;
        idle_cycles = 0;
        n_items_in = 0;
        n_items_out = 0;
        n_bad = 0;
        n_runs = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        foreach (stall_pattern[i]) stall_pattern[i] = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < 4; i++) stall_pattern[i] = 1'b0;
        clear_parser();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: blank line at once, bad method, extremes of the byte
        add_row(8'h0A, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_row(8'h00, 1'b1, 1'b0, 1'b0, 32'd0);
        add_row(8'hFF, 1'b0, 1'b0, 1'b0, 32'd0);
        add_row(8'h20, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_row(8'hFF, 1'b0, 1'b0, 1'b0, 32'd0);
        foreach (rows[i]) begin
            send_byte(rows[i].data, rows[i].newconn);
            if (rows[i].has_result && (expected_items.size() == 0 ||
                expected_items[$] !== rows[i].result))
                report_mismatch("table entry", 32'(n_items_in),
                                32'(rows[i].result.status));
        end

        // directed requests: good one with saturation, negative saturation,
        // extra word, long word, dot-dot path, missing slash, missing protocol,
        // longest path
        k = stream.size();
        add_text("GET /a?q HTTP/1.0\r\nContent-Length: 99999999999\r\n\r\n");
        newconn_q[k] = 1'b1;
        k = stream.size();
        add_text("GET /x HTTP/1.0\ncontent-length :-99999999999\n\n");
        newconn_q[k] = 1'b1;
        k = stream.size();
        add_text("GET / HTTP/1.0 x\n");
        newconn_q[k] = 1'b1;
        k = stream.size();
        add_text(rand_word(64, 0));
        newconn_q[k] = 1'b1;
        k = stream.size();
        add_text("GET /..\n");
        newconn_q[k] = 1'b1;
        k = stream.size();
        add_text("GET x\n");
        newconn_q[k] = 1'b1;
        k = stream.size();
        add_text("GET /p\n");
        newconn_q[k] = 1'b1;
        k = stream.size();
        add_text({"GET /", rand_word(62, 0), " HTTP/1.0\n\n"});
        newconn_q[k] = 1'b1;

        while (stream.size() < N_ITEMS + 60) build_request();
        // trailing noise with random connection flags
        repeat (8) begin
            stream.push_back(byte'($urandom_range(0, 255)));
            newconn_q.push_back($urandom_range(0, 7) == 0);
        end

        while (stream.size() > 0) begin
            k = $urandom_range(1, 40);
            while (k > 0 && stream.size() > 0) begin
                send_byte(stream.pop_front(), newconn_q.pop_front());
                k--;
            end
            if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 6));
        end
        in_valid <= 1'b0;

        while (expected_items.size() > 0) @(negedge clk);
        repeat (20) @(negedge clk);

        $display("%0d bytes sent, %0d items checked: %0d path runs, %0d bad requests",
                 n_items_in, n_items_out, n_runs, n_bad);
        if (errors == 0 && expected_items.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d items outstanding", errors,
                     expected_items.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
